### rtl/core/bfca_pkg.sv
// bfca_pkg: shared constants, codes and types of the best-fit cell allocator
// used by bfca_run_tracker and best_fit_cell_allocator; depends on nothing

package bfca_pkg;

  localparam int unsigned MEM_CELLS = 256;
  localparam int unsigned ID_BITS   = 8;
  localparam int unsigned REQ_W     = 9;
  localparam int unsigned ID_IN_W   = 8;
  localparam int unsigned ADDR_OUT_W = 8;
  localparam int unsigned CNT_OUT_W = 9;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    STAT_PLACED    = 3'd0,
    STAT_COMPACTED = 3'd1,
    STAT_NO_MEM    = 3'd2,
    STAT_RELEASED  = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REL,
    S_SCAN,
    S_DECIDE,
    S_FILL,
    S_HCLR,
    S_HRD,
    S_HID,
    S_HWR,
    S_CFREE,
    S_CRD,
    S_CGET,
    S_CWR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic valid;
    logic is_free;
    logic flush;
    logic clear;
  } cell_t;

endpackage

### rtl/core/bfca_ram.sv
// bfca_ram: generic single-write, single-read ram with registered read data
// no dependencies

module bfca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bfca_run_tracker.sv
// bfca_run_tracker: follows free runs of the cell stream, keeps the smallest run that fits
// depends on bfca_pkg

module bfca_run_tracker #(
  parameter int unsigned MemCells = bfca_pkg::MEM_CELLS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfca_pkg::cell_t             cell_i,
  input  logic [$clog2(MemCells)-1:0] addr_i,
  input  logic [bfca_pkg::REQ_W-1:0]  req_i,
  output logic                        found_o,
  output logic [$clog2(MemCells)-1:0] best_at_o
);

  localparam int unsigned AddrW = $clog2(MemCells);
  localparam int unsigned CntW  = $clog2(MemCells + 1);
  localparam int unsigned WideW = CntW + bfca_pkg::REQ_W;

  logic [CntW-1:0]  run_len_q, run_len_d;
  logic [AddrW-1:0] run_at_q, run_at_d;
  logic [CntW-1:0]  best_len_q, best_len_d;
  logic [AddrW-1:0] best_at_q, best_at_d;
  logic             found_q, found_d;
  logic             fits;

  assign fits = (WideW'(run_len_q) >= WideW'(req_i)) && (!found_q || run_len_q < best_len_q);

  always_comb begin
    run_len_d  = run_len_q;
    run_at_d   = run_at_q;
    best_len_d = best_len_q;
    best_at_d  = best_at_q;
    found_d    = found_q;
    if (cell_i.clear) begin
      run_len_d = '0;
      found_d   = 1'b0;
    end else if (cell_i.valid && cell_i.is_free) begin
      if (run_len_q == '0) begin
        run_at_d = addr_i;
      end
      run_len_d = run_len_q + 1'b1;
    end else if (cell_i.valid || cell_i.flush) begin
      if (fits) begin
        found_d    = 1'b1;
        best_len_d = run_len_q;
        best_at_d  = run_at_q;
      end
      run_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= '0;
      found_q   <= 1'b0;
    end else begin
      run_len_q <= run_len_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_at_q   <= run_at_d;
    best_len_q <= best_len_d;
    best_at_q  <= best_at_d;
  end

  assign found_o   = found_q;
  assign best_at_o = best_at_q;

endmodule

### rtl/core/best_fit_cell_allocator.sv
// best_fit_cell_allocator: top level, sequencer around the owner map and id histogram
// depends on bfca_pkg, bfca_ram, bfca_run_tracker
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+---------------------------------------------------
//  in      | in_valid_i | in_stall_o  | opcode_i, owner_id_i, request_cells_i
//  out     | out_valid_o| out_stall_i | status_o, start_address_o, free_cells_o,
//          |            |             | released_cells_o
//
// after reset a clearing pass writes the free mark into every cell
// release and allocate each scan the map through its read port unless refused at once,
// an allocation adds a decide step and then writes its owner id into request_cells cells
// compaction adds a histogram clear, a count pass (one ram round trip per cell) and a
// rewrite of the map that packs the free cells first and then each owner id in turn
// one item at a time; a finished result waits in the output register while the
// next item is taken

module best_fit_cell_allocator #(
  parameter int unsigned MemCells = bfca_pkg::MEM_CELLS,
  parameter int unsigned IdBits   = bfca_pkg::ID_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [bfca_pkg::ID_IN_W-1:0]    owner_id_i,
  input  logic [bfca_pkg::REQ_W-1:0]      request_cells_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [bfca_pkg::ADDR_OUT_W-1:0] start_address_o,
  output logic [bfca_pkg::CNT_OUT_W-1:0]  free_cells_o,
  output logic [bfca_pkg::CNT_OUT_W-1:0]  released_cells_o
);

  localparam int unsigned AddrW   = $clog2(MemCells);
  localparam int unsigned CntW    = $clog2(MemCells + 1);
  localparam int unsigned IdCount = 2 ** IdBits;
  localparam int unsigned IdxW    = (CntW > IdBits + 1) ? CntW : IdBits + 1;
  localparam int unsigned WideW   = CntW + bfca_pkg::REQ_W;
  localparam logic [IdBits-1:0] FreeMark = {IdBits{1'b1}};

  bfca_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_addr_q, pend_addr_d;
  logic [IdBits-1:0] id_q, id_d;
  logic [IdBits-1:0] cid_q, cid_d;
  logic [bfca_pkg::REQ_W-1:0] req_q, req_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   rel_q, rel_d;
  logic [CntW-1:0]   free_q, free_d;
  bfca_pkg::status_e status_q, status_d;
  logic [AddrW-1:0]  start_q, start_d;

  logic              out_valid_q, out_valid_d;
  bfca_pkg::status_e out_status_q, out_status_d;
  logic [bfca_pkg::ADDR_OUT_W-1:0] out_start_q, out_start_d;
  logic [bfca_pkg::CNT_OUT_W-1:0]  out_free_q, out_free_d;
  logic [bfca_pkg::CNT_OUT_W-1:0]  out_rel_q, out_rel_d;

  logic              map_we;
  logic [AddrW-1:0]  map_waddr, map_raddr;
  logic [IdBits-1:0] map_wdata, map_rdata;
  logic              hist_we;
  logic [IdBits-1:0] hist_waddr, hist_raddr;
  logic [CntW-1:0]   hist_wdata, hist_rdata;

  bfca_pkg::cell_t   trk_cell;
  logic              trk_found;
  logic [AddrW-1:0]  trk_best_at;

  logic              in_accept;
  logic [IdBits-1:0] in_id;
  logic              scan_end;

  bfca_ram #(
    .Width(IdBits),
    .Depth(MemCells)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  bfca_ram #(
    .Width(CntW),
    .Depth(IdCount)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  bfca_run_tracker #(
    .MemCells(MemCells)
  ) u_run_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (trk_cell),
    .addr_i   (pend_addr_q),
    .req_i    (req_q),
    .found_o  (trk_found),
    .best_at_o(trk_best_at)
  );

  assign in_stall_o = (state_q != bfca_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_id      = IdBits'(owner_id_i);
  assign scan_end   = (cnt_q == IdxW'(MemCells)) && !pend_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    id_d         = id_q;
    cid_d        = cid_q;
    req_d        = req_q;
    rem_d        = rem_q;
    pos_d        = pos_q;
    rel_d        = rel_q;
    free_d       = free_q;
    status_d     = status_q;
    start_d      = start_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_free_d   = out_free_q;
    out_rel_d    = out_rel_q;
    map_we       = 1'b0;
    map_waddr    = cnt_q[AddrW-1:0];
    map_wdata    = FreeMark;
    map_raddr    = cnt_q[AddrW-1:0];
    hist_we      = 1'b0;
    hist_waddr   = cid_q;
    hist_wdata   = '0;
    hist_raddr   = cid_q;
    trk_cell     = '0;

    case (state_q)
      bfca_pkg::S_CLEAR: begin
        map_we = 1'b1;
        if (cnt_q == IdxW'(MemCells - 1)) begin
          cnt_d   = '0;
          state_d = bfca_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      bfca_pkg::S_IDLE: begin
        if (in_accept) begin
          id_d    = in_id;
          req_d   = request_cells_i;
          cnt_d   = '0;
          pend_d  = 1'b0;
          rel_d   = '0;
          start_d = '0;
          if (opcode_i == bfca_pkg::OP_RELEASE) begin
            if (in_id == FreeMark) begin
              status_d = bfca_pkg::STAT_NOT_FOUND;
              state_d  = bfca_pkg::S_DONE;
            end else begin
              state_d = bfca_pkg::S_REL;
            end
          end else if (in_id == FreeMark || request_cells_i == '0 ||
                       WideW'(request_cells_i) > WideW'(free_q)) begin
            status_d = bfca_pkg::STAT_NO_MEM;
            state_d  = bfca_pkg::S_DONE;
          end else begin
            trk_cell.clear = 1'b1;
            state_d        = bfca_pkg::S_SCAN;
          end
        end
      end

      bfca_pkg::S_REL, bfca_pkg::S_SCAN: begin
        if (cnt_q < IdxW'(MemCells)) begin
          cnt_d       = cnt_q + 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = cnt_q[AddrW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (state_q == bfca_pkg::S_REL) begin
          if (pend_q && map_rdata == id_q) begin
            map_we    = 1'b1;
            map_waddr = pend_addr_q;
            rel_d     = rel_q + 1'b1;
          end
          if (scan_end) begin
            free_d   = free_q + rel_q;
            status_d = (rel_q != '0) ? bfca_pkg::STAT_RELEASED : bfca_pkg::STAT_NOT_FOUND;
            state_d  = bfca_pkg::S_DONE;
          end
        end else begin
          trk_cell.valid   = pend_q;
          trk_cell.is_free = (map_rdata == FreeMark);
          trk_cell.flush   = scan_end;
          if (scan_end) begin
            state_d = bfca_pkg::S_DECIDE;
          end
        end
      end

      bfca_pkg::S_DECIDE: begin
        rem_d = CntW'(req_q);
        if (trk_found) begin
          status_d = bfca_pkg::STAT_PLACED;
          start_d  = trk_best_at;
          cnt_d    = IdxW'(trk_best_at);
          state_d  = bfca_pkg::S_FILL;
        end else begin
          status_d = bfca_pkg::STAT_COMPACTED;
          start_d  = '0;
          cnt_d    = '0;
          state_d  = bfca_pkg::S_HCLR;
        end
      end

      bfca_pkg::S_FILL: begin
        map_we    = 1'b1;
        map_wdata = id_q;
        cnt_d     = cnt_q + 1'b1;
        rem_d     = rem_q - 1'b1;
        if (rem_q == CntW'(1)) begin
          free_d  = free_q - CntW'(req_q);
          state_d = bfca_pkg::S_DONE;
        end
      end

      bfca_pkg::S_HCLR: begin
        hist_we    = 1'b1;
        hist_waddr = cnt_q[IdBits-1:0];
        if (cnt_q == IdxW'(IdCount - 1)) begin
          cnt_d   = '0;
          state_d = bfca_pkg::S_HRD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      bfca_pkg::S_HRD: begin
        state_d = bfca_pkg::S_HID;
      end

      bfca_pkg::S_HID: begin
        hist_raddr = map_rdata;
        cid_d      = map_rdata;
        state_d    = bfca_pkg::S_HWR;
      end

      bfca_pkg::S_HWR: begin
        hist_we    = 1'b1;
        hist_wdata = hist_rdata + 1'b1;
        if (cnt_q == IdxW'(MemCells - 1)) begin
          pos_d   = '0;
          rem_d   = free_q;
          state_d = bfca_pkg::S_CFREE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = bfca_pkg::S_HRD;
        end
      end

      bfca_pkg::S_CFREE: begin
        if (rem_q == '0) begin
          cid_d   = '0;
          state_d = bfca_pkg::S_CRD;
        end else begin
          map_we    = 1'b1;
          map_waddr = pos_q[AddrW-1:0];
          pos_d     = pos_q + 1'b1;
          rem_d     = rem_q - 1'b1;
        end
      end

      bfca_pkg::S_CRD: begin
        state_d = bfca_pkg::S_CGET;
      end

      bfca_pkg::S_CGET: begin
        rem_d   = hist_rdata;
        state_d = bfca_pkg::S_CWR;
      end

      bfca_pkg::S_CWR: begin
        if (rem_q == '0) begin
          if (cid_q == FreeMark - 1'b1) begin
            cnt_d   = '0;
            rem_d   = CntW'(req_q);
            state_d = bfca_pkg::S_FILL;
          end else begin
            cid_d   = cid_q + 1'b1;
            state_d = bfca_pkg::S_CRD;
          end
        end else begin
          map_we    = 1'b1;
          map_waddr = pos_q[AddrW-1:0];
          map_wdata = cid_q;
          pos_d     = pos_q + 1'b1;
          rem_d     = rem_q - 1'b1;
        end
      end

      bfca_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_start_d  = bfca_pkg::ADDR_OUT_W'(start_q);
          out_free_d   = bfca_pkg::CNT_OUT_W'(free_q);
          out_rel_d    = bfca_pkg::CNT_OUT_W'(rel_q);
          state_d      = bfca_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bfca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfca_pkg::S_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      free_q      <= CntW'(MemCells);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    id_q         <= id_d;
    cid_q        <= cid_d;
    req_q        <= req_d;
    rem_q        <= rem_d;
    pos_q        <= pos_d;
    rel_q        <= rel_d;
    status_q     <= status_d;
    start_q      <= start_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_free_q   <= out_free_d;
    out_rel_q    <= out_rel_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign start_address_o  = out_start_q;
  assign free_cells_o     = out_free_q;
  assign released_cells_o = out_rel_q;

`ifndef ASSERT_OFF
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CntW'(MemCells))
    else $error("free count above map size");

  a_rel_only_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bfca_pkg::STAT_RELEASED) |-> released_cells_o == '0)
    else $error("released cells reported without a release");

  a_fill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfca_pkg::S_FILL) |-> rem_q != '0)
    else $error("fill with nothing left to place");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfca_pkg::S_CLEAR) |-> in_stall_o)
    else $error("item taken during map clear");
`endif

endmodule
